// ===== rtl/core/percent_escape_decoder_assert.svh =====
// Assertion macros shared by the percent-escape decoder RTL.
// Included by the top level; needs a clock named clk and a reset named arst_n in scope.
`ifndef PERCENT_ESCAPE_DECODER_ASSERT_SVH
`define PERCENT_ESCAPE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge while reset is released.
`define PED_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PED_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PED_ASSERT(label, prop, msg)
`define PED_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/core/ped_pkg.sv =====
// Shared types and constants of the percent-escape decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ped_pkg;

	// Depth of the queue between the front and the back.
	localparam int FIFO_DEPTH = 2;

	// Characters that drive the decoding.
	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_0       = 8'h30;
	localparam logic [7:0] CHAR_9       = 8'h39;
	localparam logic [7:0] CHAR_UA      = 8'h41;
	localparam logic [7:0] CHAR_UF      = 8'h46;
	localparam logic [7:0] CHAR_LA      = 8'h61;
	localparam logic [7:0] CHAR_LF      = 8'h66;
	localparam logic [7:0] HEX_TEN      = 8'd10;

	// One decoded result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       last_of_token;
	} result_t;

	// One queue entry: the results caused by one input item.
	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    two;
	} entry_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== rtl/core/ped_front.sv =====
// Front of the percent-escape decoder: accepts bytes, runs the escape state machine
// and pushes the one or two results of each byte that has any into the queue. Depends on ped_pkg.
module ped_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                token_end,
	input  ped_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output ped_pkg::entry_t     push_data
);

	typedef enum logic [1:0] {
		MODE_COPY,
		MODE_ESCAPE,
		MODE_ONEDIG,
		MODE_LITERAL
	} mode_t;

	mode_t      mode_q;
	logic [3:0] held_q;

	mode_t           mode_d;
	logic [3:0]      held_d;
	logic [1:0]      cnt;
	ped_pkg::entry_t ent;
	logic [4:0]      hex;
	logic [7:0]      val;
	logic            accept;

	// Returns {is_hex, value} for one byte; either letter case is taken.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [7:0] d;
		d = 8'd0;
		if (b >= ped_pkg::CHAR_0 && b <= ped_pkg::CHAR_9) begin
			d = b - ped_pkg::CHAR_0;
			return {1'b1, d[3:0]};
		end
		if (b >= ped_pkg::CHAR_UA && b <= ped_pkg::CHAR_UF) begin
			d = b - ped_pkg::CHAR_UA + ped_pkg::HEX_TEN;
			return {1'b1, d[3:0]};
		end
		if (b >= ped_pkg::CHAR_LA && b <= ped_pkg::CHAR_LF) begin
			d = b - ped_pkg::CHAR_LA + ped_pkg::HEX_TEN;
			return {1'b1, d[3:0]};
		end
		return {1'b0, d[3:0]};
	endfunction

	assign in_ready = !fifo_stat.full;
	assign accept   = in_valid && in_ready;
	assign hex      = hex_decode(data_byte);
	assign val      = {held_q, hex[3:0]};

	// Next state and the results of the current byte.
	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		cnt    = 2'd0;
		ent    = '0;
		unique case (mode_q)
			MODE_COPY: begin
				if (data_byte == ped_pkg::CHAR_PERCENT) begin
					mode_d = MODE_ESCAPE;
				end else begin
					ent.r0.out_byte = data_byte;
					ent.r0.has_byte = 1'b1;
					cnt             = 2'd1;
				end
			end
			MODE_ESCAPE: begin
				if (hex[4]) begin
					held_d = hex[3:0];
					mode_d = MODE_ONEDIG;
				end else begin
					ent.r0.out_byte = data_byte;
					ent.r0.has_byte = 1'b1;
					cnt             = 2'd1;
					mode_d          = MODE_COPY;
				end
			end
			MODE_ONEDIG: begin
				if (hex[4]) begin
					if (val != 8'd0) begin
						ent.r0.out_byte = val;
						ent.r0.has_byte = 1'b1;
						cnt             = 2'd1;
						mode_d          = MODE_COPY;
					end else begin
						mode_d = MODE_LITERAL;
					end
				end else if (held_q != 4'd0) begin
					// Flush the held digit, then treat the byte as in copy mode.
					ent.r0.out_byte = {4'd0, held_q};
					ent.r0.has_byte = 1'b1;
					cnt             = 2'd1;
					mode_d          = MODE_COPY;
					if (data_byte == ped_pkg::CHAR_PERCENT) begin
						mode_d = MODE_ESCAPE;
					end else begin
						ent.r1.out_byte = data_byte;
						ent.r1.has_byte = 1'b1;
						cnt             = 2'd2;
					end
				end else begin
					ent.r0.out_byte = data_byte;
					ent.r0.has_byte = 1'b1;
					cnt             = 2'd1;
					mode_d          = MODE_COPY;
				end
			end
			MODE_LITERAL: begin
				ent.r0.out_byte = data_byte;
				ent.r0.has_byte = 1'b1;
				cnt             = 2'd1;
				mode_d          = MODE_COPY;
			end
			default: begin
				mode_d = MODE_COPY;
			end
		endcase

		// At the end of the token, flush a held digit or emit an empty marker.
		if (token_end) begin
			if (mode_d == MODE_ONEDIG && held_d != 4'd0) begin
				ent.r0.out_byte = {4'd0, held_d};
				ent.r0.has_byte = 1'b1;
				cnt             = 2'd1;
			end
			if (cnt == 2'd0) begin
				ent.r0.out_byte = 8'd0;
				ent.r0.has_byte = 1'b0;
				cnt             = 2'd1;
			end
			ent.r0.last_of_token = (cnt == 2'd1);
			ent.r1.last_of_token = (cnt == 2'd2);
			mode_d               = MODE_COPY;
			held_d               = 4'd0;
		end
		ent.two = (cnt == 2'd2);
	end

	assign push      = accept && (cnt != 2'd0);
	assign push_data = ent;

	// Decoder state advances on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_COPY;
			held_q <= 4'd0;
		end else if (accept) begin
			mode_q <= mode_d;
			held_q <= held_d;
		end
	end

endmodule

// ===== rtl/core/ped_fifo.sv =====
// Short queue between the front and the back of the percent-escape decoder.
// Holds one entry per input byte that produced results. Depends on ped_pkg.
module ped_fifo #(
	parameter int Depth = ped_pkg::FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  ped_pkg::entry_t            push_data,
	input  logic                       pop,
	output ped_pkg::entry_t            pop_data,
	output ped_pkg::fifo_stat_t        stat,
	output logic [$clog2(Depth+1)-1:0] level
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	ped_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CntW'(Depth));
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign level      = cnt_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/ped_back.sv =====
// Back of the percent-escape decoder: takes queue entries and delivers their
// results one per cycle through the output register while out_ready is high. Depends on ped_pkg.
module ped_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ped_pkg::entry_t     head,
	input  ped_pkg::fifo_stat_t fifo_stat,
	output logic                pop,
	output logic                pend_valid,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                has_byte,
	output logic                last_of_token
);

	ped_pkg::result_t out_q;
	ped_pkg::result_t pend_q;
	logic             out_valid_q;
	logic             pend_valid_q;
	logic             load;

	// The output register takes a new result whenever it is empty or being drained.
	assign load = !out_valid_q || out_ready;
	assign pop  = load && !pend_valid_q && !fifo_stat.empty;

	// Valid flags of the output register and the second-result holding register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (!fifo_stat.empty) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= head.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payloads.
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (!fifo_stat.empty) begin
				out_q  <= head.r0;
				pend_q <= head.r1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pend_valid    = pend_valid_q;
	assign out_byte      = out_q.out_byte;
	assign has_byte      = out_q.has_byte;
	assign last_of_token = out_q.last_of_token;

endmodule

// ===== rtl/core/percent_escape_decoder.sv =====
// Percent-escape decoder, top level: front, queue and back.
// An accepted byte's results pass through the queue into the output register.
// Throughput is one byte per cycle while the queue is not full; a byte with two results
// holds the back while both leave the single output register, and the queue absorbs the slip.
// Reset (arst_n low, asynchronous) returns to copy mode and empties queue and output.
`include "percent_escape_decoder_assert.svh"

module percent_escape_decoder #(
	parameter int FifoDepth = ped_pkg::FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       token_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       last_of_token
);

	localparam int CntW = $clog2(FifoDepth + 1);

	ped_pkg::fifo_stat_t fifo_stat;
	ped_pkg::entry_t     push_data;
	ped_pkg::entry_t     head;
	logic                push;
	logic                pop;
	logic                pend_valid;
	logic [CntW-1:0]     level;

	ped_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.token_end (token_end),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_data (push_data)
	);

	ped_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.stat      (fifo_stat),
		.level     (level)
	);

	ped_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.fifo_stat     (fifo_stat),
		.pop           (pop),
		.pend_valid    (pend_valid),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.last_of_token (last_of_token)
	);

	// The queue never holds more entries than its depth.
	`PED_ASSERT(a_fifo_bound, level <= CntW'(FifoDepth), "queue fill exceeds its depth")
	// A held second result always sits behind a valid output.
	`PED_ASSERT(a_pend_behind_out, pend_valid |-> out_valid, "second result without output")
	// An empty end marker carries no byte and always closes the token.
	`PED_ASSERT(a_marker_last, (out_valid && !has_byte) |-> (last_of_token && out_byte == 8'd0),
		"end marker malformed")
	// A pop of the queue only happens when it is not empty.
	`PED_ASSERT(a_pop_nonempty, pop |-> !fifo_stat.empty, "pop from empty queue")

endmodule

// ===== tb/percent_escape_decoder_tb.sv =====
// Self-checking testbench for percent_escape_decoder: byte streams with random idling on both
// handshakes, checked against an in-bench model of the escape decoding.
// Depends on ped_pkg and the percent_escape_decoder RTL.
module percent_escape_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Decoder states as the model tracks them.
	typedef enum logic [1:0] {
		ST_COPY,
		ST_PCT,
		ST_DIGIT,
		ST_VERBATIM
	} dec_state_t;

	// One encoded item waiting to be sent.
	typedef struct {
		logic [7:0] b;
		logic       fin;
	} enc_item_t;

	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_TAIL    = 40;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       token_end = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       last_of_token;

	enc_item_t        pending_items[$];
	ped_pkg::result_t expected_results[$];
	int               error_count  = 0;
	int               results_seen = 0;
	int               send_gap     = 0;
	int               stall_left   = 0;
	enc_item_t        next_item;
	ped_pkg::result_t want;
	dec_state_t       dec_state    = ST_COPY;
	logic [3:0]       held_digit   = 4'h0;

	percent_escape_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.token_end    (token_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.has_byte     (has_byte),
		.last_of_token(last_of_token)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Returns 1 and the digit value when b is a hex digit of either case.
	function automatic bit hex_of(input logic [7:0] b, output logic [3:0] v);
		v = 4'h0;
		if (b >= ped_pkg::CHAR_0 && b <= ped_pkg::CHAR_9) begin
			v = 4'(b - ped_pkg::CHAR_0);
			return 1'b1;
		end
		if (b >= ped_pkg::CHAR_UA && b <= ped_pkg::CHAR_UF) begin
			v = 4'(b - ped_pkg::CHAR_UA + ped_pkg::HEX_TEN);
			return 1'b1;
		end
		if (b >= ped_pkg::CHAR_LA && b <= ped_pkg::CHAR_LF) begin
			v = 4'(b - ped_pkg::CHAR_LA + ped_pkg::HEX_TEN);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void push_result(input logic [7:0] v, input logic has);
		expected_results.push_back('{out_byte: v, has_byte: has, last_of_token: 1'b0});
	endfunction

	// Advances the decoder model by one accepted byte and queues the results it causes.
	function automatic void decode_step(input logic [7:0] b, input logic fin);
		logic [3:0] v;
		logic       is_hex;
		int         base;
		base   = expected_results.size();
		is_hex = hex_of(b, v);
		case (dec_state)
			ST_COPY: begin
				if (b == ped_pkg::CHAR_PERCENT)
					dec_state = ST_PCT;
				else
					push_result(b, 1'b1);
			end
			ST_PCT: begin
				if (is_hex) begin
					held_digit = v;
					dec_state  = ST_DIGIT;
				end else begin
					push_result(b, 1'b1);
					dec_state = ST_COPY;
				end
			end
			ST_DIGIT: begin
				if (is_hex) begin
					// A zero value emits nothing and lets the next byte through as is.
					if ({held_digit, v} != 8'h00) begin
						push_result({held_digit, v}, 1'b1);
						dec_state = ST_COPY;
					end else begin
						dec_state = ST_VERBATIM;
					end
				end else if (held_digit != 4'h0) begin
					// Flush the single digit, then treat the byte as in copy mode.
					push_result({4'h0, held_digit}, 1'b1);
					dec_state = ST_COPY;
					if (b == ped_pkg::CHAR_PERCENT)
						dec_state = ST_PCT;
					else
						push_result(b, 1'b1);
				end else begin
					push_result(b, 1'b1);
					dec_state = ST_COPY;
				end
			end
			default: begin
				push_result(b, 1'b1);
				dec_state = ST_COPY;
			end
		endcase

		// End of token: flush a held digit, mark the last result, start fresh.
		if (fin) begin
			if (dec_state == ST_DIGIT && held_digit != 4'h0)
				push_result({4'h0, held_digit}, 1'b1);
			if (expected_results.size() == base)
				push_result(8'h00, 1'b0);
			expected_results[expected_results.size() - 1].last_of_token = 1'b1;
			dec_state  = ST_COPY;
			held_digit = 4'h0;
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
		error_count++;
	endtask

	function automatic void add_item(input logic [7:0] b, input logic fin);
		pending_items.push_back('{b: b, fin: fin});
	endfunction

	function automatic void add_token(input string s);
		for (int i = 0; i < s.len(); i++)
			add_item(s[i], i == s.len() - 1);
	endfunction

	// Byte mix that favors escapes and hex digits so the deeper states are reached.
	function automatic logic [7:0] pick_token_byte();
		string hex_chars;
		int    r;
		hex_chars = "0123456789abcdefABCDEF";
		r = $urandom_range(0, 99);
		if (r < 25)
			return ped_pkg::CHAR_PERCENT;
		if (r < 38)
			return ped_pkg::CHAR_0;
		if (r < 70)
			return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
		if (r < 88)
			return 8'($urandom_range(8'h21, 8'h7e));
		return 8'($urandom_range(0, 255));
	endfunction

	// Driver: presents pending items and feeds each accepted one to the model.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			data_byte <= 8'h00;
			token_end <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				decode_step(data_byte, token_end);
			if (in_valid && !in_ready) begin
				// Hold the item until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				in_valid  <= 1'b1;
				data_byte <= next_item.b;
				token_end <= next_item.fin;
				if (pending_items.size() > CALM_TAIL && (pending_items.size() / 40) % 3 != 0
						&& $urandom_range(0, 99) < 25)
					send_gap = $urandom_range(1, 12);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each taken result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected", out_byte, 0);
				end else begin
					want = expected_results.pop_front();
					if (out_byte !== want.out_byte)
						report_mismatch("out_byte", out_byte, want.out_byte);
					if (has_byte !== want.has_byte)
						report_mismatch("has_byte", has_byte, want.has_byte);
					if (last_of_token !== want.last_of_token)
						report_mismatch("last_of_token", last_of_token, want.last_of_token);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (pending_items.size() > CALM_TAIL && (results_seen / 50) % 3 != 1
					&& $urandom_range(0, 99) < 20) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int n;
		int len;
		// Escape corners: double percent, lone percent, two and one digit escapes,
		// flushed digit, zero escapes, high bytes.
		add_token("%%");
		add_token("%");
		add_token("%41");
		add_token("%4");
		add_token("%4g");
		add_token("%0g");
		add_token("%00%");
		add_token("%fF");
		add_token("%0");
		add_item(8'h00, 1'b1);
		add_item(8'hFF, 1'b0);
		add_item(8'h80, 1'b1);

		// Mostly well-formed tokens with random content, some raw noise.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				n++;
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					add_item(pick_token_byte(), i == len - 1);
				n += len;
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("percent_escape_decoder_tb: clean");
		else
			$display("percent_escape_decoder_tb: errors");
		$finish;
	end

	// Run limit, far beyond the slowest legal run.
	initial begin
		#2ms;
		$display("percent_escape_decoder_tb: errors");
		$finish;
	end

endmodule
